/* sv/sog_pkg.sv */
// Shared types, field widths and helpers for the spiral order address generator.
// No dependencies; imported by sog_step and spiral_order_address_generator.
package sog_pkg;

  // walk direction codes
  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  // fixed field widths
  localparam int SIDE_REG_W = 9;
  localparam int ROW_W      = 8;
  localparam int COL_W      = 8;
  localparam int ADDR_W     = 16;
  localparam int VALUE_W    = 17;

  // defaults for the internal widths at the default size
  localparam int MAX_SIDE_DEFAULT = 256;
  localparam int SIDE_W_DEFAULT   = 9;
  localparam int POS_W_DEFAULT    = 8;
  localparam int COUNT_W_DEFAULT  = 17;

  localparam logic [SIDE_REG_W-1:0] SIDE_RESET = 9'd4;

  // register file
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_SIDE_LENGTH = 1'b0;

  // side as used by the walk: zero reads as one, anything above cap reads as cap
  function automatic logic [SIDE_REG_W-1:0] clamp_side(
    input logic [SIDE_REG_W-1:0] raw,
    input int                    cap
  );
    logic [SIDE_REG_W-1:0] res;
    res = raw;
    if (raw == '0) begin
      res = SIDE_REG_W'(1);
    end else if (int'(raw) > cap) begin
      res = SIDE_REG_W'(cap);
    end
    return res;
  endfunction

endpackage

/* sv/sog_step.sv */
// One step of the clockwise spiral walk: current cell, last flag and next walk state.
// Pure combinational; depends on sog_pkg.
module sog_step #(
  parameter int SW = sog_pkg::SIDE_W_DEFAULT,
  parameter int PW = sog_pkg::POS_W_DEFAULT,
  parameter int CW = sog_pkg::COUNT_W_DEFAULT
) (
  input  logic           restart,
  input  logic [SW-1:0]  side,
  input  logic [SW-1:0]  top,
  input  logic [SW-1:0]  bottom,
  input  logic [SW-1:0]  left,
  input  logic [SW-1:0]  right,
  input  logic [PW-1:0]  row,
  input  logic [PW-1:0]  col,
  input  sog_pkg::dir_t  dir,
  input  logic [CW-1:0]  count,
  input  logic [CW-1:0]  addr,
  output logic [PW-1:0]  out_row,
  output logic [PW-1:0]  out_col,
  output logic [CW-1:0]  out_addr,
  output logic [CW-1:0]  out_count,
  output logic           out_last,
  output logic [SW-1:0]  top_next,
  output logic [SW-1:0]  bottom_next,
  output logic [SW-1:0]  left_next,
  output logic [SW-1:0]  right_next,
  output logic [PW-1:0]  row_next,
  output logic [PW-1:0]  col_next,
  output sog_pkg::dir_t  dir_next,
  output logic [CW-1:0]  count_next,
  output logic [CW-1:0]  addr_next
);
  import sog_pkg::*;

  logic [SW-1:0] top_c, bottom_c, left_c, right_c;
  logic [PW-1:0] row_c, col_c;
  dir_t          dir_c;
  logic [CW-1:0] count_c, addr_c, total, side_c;

  always_comb begin
    side_c = CW'(side);
    total  = CW'(side) * CW'(side);

    if (restart) begin
      top_c    = '0;
      bottom_c = side;
      left_c   = '0;
      right_c  = side;
      row_c    = '0;
      col_c    = '0;
      dir_c    = DIR_RIGHT;
      count_c  = CW'(1);
      addr_c   = '0;
    end else begin
      top_c    = top;
      bottom_c = bottom;
      left_c   = left;
      right_c  = right;
      row_c    = row;
      col_c    = col;
      dir_c    = dir;
      count_c  = count;
      addr_c   = addr;
    end

    out_row   = row_c;
    out_col   = col_c;
    out_addr  = addr_c;
    out_count = count_c;
    out_last  = (count_c >= total);

    top_next    = top_c;
    bottom_next = bottom_c;
    left_next   = left_c;
    right_next  = right_c;
    row_next    = row_c;
    col_next    = col_c;
    dir_next    = dir_c;
    count_next  = count_c + CW'(1);
    addr_next   = addr_c;

    if (out_last) begin
      // wrap to the top-left cell
      top_next    = '0;
      bottom_next = side;
      left_next   = '0;
      right_next  = side;
      row_next    = '0;
      col_next    = '0;
      dir_next    = DIR_RIGHT;
      count_next  = CW'(1);
      addr_next   = '0;
    end else begin
      // address tracks row*side+col: +-1 across, +-side down/up
      unique case (dir_c)
        DIR_RIGHT: begin
          if (SW'(col_c) + SW'(1) < right_c) begin
            col_next  = col_c + PW'(1);
            addr_next = addr_c + CW'(1);
          end else begin
            top_next  = top_c + SW'(1);
            dir_next  = DIR_DOWN;
            row_next  = row_c + PW'(1);
            addr_next = addr_c + side_c;
          end
        end
        DIR_DOWN: begin
          if (SW'(row_c) + SW'(1) < bottom_c) begin
            row_next  = row_c + PW'(1);
            addr_next = addr_c + side_c;
          end else begin
            right_next = right_c - SW'(1);
            dir_next   = DIR_LEFT;
            col_next   = col_c - PW'(1);
            addr_next  = addr_c - CW'(1);
          end
        end
        DIR_LEFT: begin
          if (SW'(col_c) > left_c) begin
            col_next  = col_c - PW'(1);
            addr_next = addr_c - CW'(1);
          end else begin
            bottom_next = bottom_c - SW'(1);
            dir_next    = DIR_UP;
            row_next    = row_c - PW'(1);
            addr_next   = addr_c - side_c;
          end
        end
        DIR_UP: begin
          if (SW'(row_c) > top_c) begin
            row_next  = row_c - PW'(1);
            addr_next = addr_c - side_c;
          end else begin
            left_next = left_c + SW'(1);
            dir_next  = DIR_RIGHT;
            col_next  = col_c + PW'(1);
            addr_next = addr_c + CW'(1);
          end
        end
      endcase
    end
  end

endmodule

/* sv/spiral_order_address_generator.sv */
// Spiral order address generator: result_valid rises in the cycle after an accept;
// throughput 1 cell per cycle when not stalled, set by the single walk-state register
// updated by sog_step on each accept. One output register decouples the two sides.
// Synchronous reset: side_length = 4, walk at top-left cell, result empty.
// Writing side_length also restarts the walk. Depends on sog_pkg and sog_step.
module spiral_order_address_generator #(
  parameter int MAX_SIDE = sog_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sog_pkg::PADDR_W-1:0]   paddr,
  input  logic [sog_pkg::PDATA_W-1:0]   pwdata,
  output logic [sog_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // input items
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic                          restart,
  // results
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [sog_pkg::ROW_W-1:0]     cell_row,
  output logic [sog_pkg::COL_W-1:0]     cell_column,
  output logic [sog_pkg::ADDR_W-1:0]    cell_address,
  output logic [sog_pkg::VALUE_W-1:0]   cell_value,
  output logic                          last_cell
);
  import sog_pkg::*;

  // side register holds 9 bits, so the usable side never exceeds 511
  localparam int SIDE_CAP = (MAX_SIDE > 511) ? 511 : MAX_SIDE;
  localparam int SW       = $clog2(SIDE_CAP + 1);
  localparam int PW       = (SIDE_CAP > 1) ? $clog2(SIDE_CAP) : 1;
  localparam int CW       = $clog2(SIDE_CAP * SIDE_CAP + 1);
  localparam logic [SIDE_REG_W-1:0] RESET_SIDE = clamp_side(SIDE_RESET, SIDE_CAP);

  logic [SIDE_REG_W-1:0] side_length;
  logic [SW-1:0]         eff_side, wr_side;

  logic [SW-1:0] bound_top, bound_bottom, bound_left, bound_right;
  logic [PW-1:0] walk_row, walk_col;
  dir_t          walk_dir;
  logic [CW-1:0] walk_count, walk_addr;

  logic [SW-1:0] top_next, bottom_next, left_next, right_next;
  logic [PW-1:0] row_next, col_next;
  dir_t          dir_next;
  logic [CW-1:0] count_next, addr_next;

  logic [PW-1:0] step_row, step_col;
  logic [CW-1:0] step_addr, step_count;
  logic          step_last;

  logic cfg_write, accept;

  assign pready     = 1'b1;
  assign cfg_write  = psel & penable & pwrite & pready & (paddr[2] == REG_SIDE_LENGTH);
  assign prdata     = (paddr[2] == REG_SIDE_LENGTH) ? PDATA_W'(side_length) : '0;

  assign item_ready = ~result_valid | result_ready;
  assign accept     = item_valid & item_ready;

  assign eff_side = SW'(clamp_side(side_length, SIDE_CAP));
  assign wr_side  = SW'(clamp_side(pwdata[SIDE_REG_W-1:0], SIDE_CAP));

  sog_step #(
    .SW (SW),
    .PW (PW),
    .CW (CW)
  ) u_step (
    .restart     (restart),
    .side        (eff_side),
    .top         (bound_top),
    .bottom      (bound_bottom),
    .left        (bound_left),
    .right       (bound_right),
    .row         (walk_row),
    .col         (walk_col),
    .dir         (walk_dir),
    .count       (walk_count),
    .addr        (walk_addr),
    .out_row     (step_row),
    .out_col     (step_col),
    .out_addr    (step_addr),
    .out_count   (step_count),
    .out_last    (step_last),
    .top_next    (top_next),
    .bottom_next (bottom_next),
    .left_next   (left_next),
    .right_next  (right_next),
    .row_next    (row_next),
    .col_next    (col_next),
    .dir_next    (dir_next),
    .count_next  (count_next),
    .addr_next   (addr_next)
  );

  // walk state and side register
  always_ff @(posedge clk) begin
    if (rst) begin
      side_length  <= SIDE_RESET;
      bound_top    <= '0;
      bound_bottom <= SW'(RESET_SIDE);
      bound_left   <= '0;
      bound_right  <= SW'(RESET_SIDE);
      walk_row     <= '0;
      walk_col     <= '0;
      walk_dir     <= DIR_RIGHT;
      walk_count   <= CW'(1);
      walk_addr    <= '0;
    end else if (cfg_write) begin
      side_length  <= pwdata[SIDE_REG_W-1:0];
      bound_top    <= '0;
      bound_bottom <= wr_side;
      bound_left   <= '0;
      bound_right  <= wr_side;
      walk_row     <= '0;
      walk_col     <= '0;
      walk_dir     <= DIR_RIGHT;
      walk_count   <= CW'(1);
      walk_addr    <= '0;
    end else if (accept) begin
      bound_top    <= top_next;
      bound_bottom <= bottom_next;
      bound_left   <= left_next;
      bound_right  <= right_next;
      walk_row     <= row_next;
      walk_col     <= col_next;
      walk_dir     <= dir_next;
      walk_count   <= count_next;
      walk_addr    <= addr_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cell_row     <= ROW_W'(step_row);
      cell_column  <= COL_W'(step_col);
      cell_address <= ADDR_W'(step_addr);
      cell_value   <= VALUE_W'(step_count);
      last_cell    <= step_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    walk_count >= CW'(1) && walk_count <= CW'(eff_side) * CW'(eff_side))
    else $error("walk count outside 1..side*side");

  a_addr_track: assert property (@(posedge clk) disable iff (rst)
    walk_addr == CW'(walk_row) * CW'(eff_side) + CW'(walk_col))
    else $error("tracked address differs from row*side+col");

  a_in_matrix: assert property (@(posedge clk) disable iff (rst)
    SW'(walk_row) < eff_side && SW'(walk_col) < eff_side)
    else $error("walk position outside matrix");

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && step_last |=> walk_count == CW'(1) && walk_addr == '0)
    else $error("walk did not wrap after final cell");

  a_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted transaction produced no result");
`endif

endmodule
